[hdl/lss_pkg.sv]
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants and types for the latency statistics block.
// ----------------------------------------------------------------------------
package lss_pkg;
    localparam int LSS_NUM_PEERS = 16;
    localparam int LSS_MAX_REPS  = 64;
    localparam int PEER_W        = 4;
    localparam int LAT_W         = 24;
    localparam int TOTAL_W       = 7;
    localparam int SUM_W         = 40;
    localparam int SQ_W          = 64;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic [PEER_W-1:0]  peer;
        logic [TOTAL_W-1:0] total;
        logic [LAT_W-1:0]   mean;
        logic [LAT_W-1:0]   sd;
        logic [LAT_W-1:0]   mn;
        logic [LAT_W-1:0]   mx;
        logic [LAT_W-1:0]   med;
        logic               dropped;
        logic               last;
    } t_result;
endpackage

[hdl/latency_sample_statistics.sv]
// ----------------------------------------------------------------------------
// latency_sample_statistics
// Per-peer latency accumulation with finish-time statistics report.
// ----------------------------------------------------------------------------
// An add beat squares the latency as it is taken, then does the per-peer
// read-modify-write. A finish beat walks each reported peer: a divide for the
// mean, another for the mean square, a step to form the variance, a square
// root, then a median search that passes over the peer's stored samples once
// per candidate, trying candidates in store order until one is the median; an
// empty peer skips straight to its report, and the output register can be held
// by a stall. Results leave through an output register; the block accepts the
// next beat once the report is done.
module latency_sample_statistics
    import lss_pkg::*;
#(
    parameter int NUM_PEERS = LSS_NUM_PEERS,
    parameter int MAX_REPS  = LSS_MAX_REPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic [PEER_W-1:0]  i_peer,
    input  logic [LAT_W-1:0]   i_latency,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PEER_W-1:0]  o_peer_out,
    output logic [TOTAL_W-1:0] o_sample_total,
    output logic [LAT_W-1:0]   o_mean,
    output logic [LAT_W-1:0]   o_std_dev,
    output logic [LAT_W-1:0]   o_minimum,
    output logic [LAT_W-1:0]   o_maximum,
    output logic [LAT_W-1:0]   o_median,
    output logic               o_dropped,
    output logic               o_last
);
    localparam int NP    = (NUM_PEERS < 16) ? NUM_PEERS : 16;
    localparam int RW    = (MAX_REPS > 1) ? $clog2(MAX_REPS) : 1;
    localparam int CW    = $clog2(MAX_REPS + 1);
    localparam int PW    = (NP > 1) ? $clog2(NP) : 1;
    localparam int DEPTH = NP * MAX_REPS;
    localparam int AW    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ADD   = 10'b0000000010,
        S_DIV1  = 10'b0000000100,
        S_DIV2  = 10'b0000001000,
        S_SQ    = 10'b0000010000,
        S_SQRT  = 10'b0000100000,
        S_MSCAN = 10'b0001000000,
        S_MWAIT = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_DIVW  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]    r_cnt  [NP];
    logic [SUM_W-1:0] r_sum  [NP];
    logic [SQ_W-1:0]  r_sq   [NP];
    logic [LAT_W-1:0] r_min  [NP];
    logic [LAT_W-1:0] r_max  [NP];
    logic             r_ovf  [NP];

    logic [PW-1:0]    r_apeer;
    logic [LAT_W-1:0] r_alat;
    logic [47:0]      r_alat2;
    logic [PW-1:0]    r_p;
    logic [LAT_W-1:0] r_mean;
    logic [SQ_W-1:0]  r_msq;
    logic [LAT_W-1:0] r_sd;
    logic [RW-1:0]    r_cand;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_less, r_leq;
    logic [LAT_W-1:0] r_cval;
    logic [LAT_W-1:0] r_med;
    logic             r_rd_v;
    logic             r_rd_c;
    t_result          r_out;
    logic             r_ovalid;

    logic             w_accept;
    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [LAT_W-1:0] w_rdata;
    logic             w_start, w_sqrt, w_done;
    logic [SQ_W-1:0]  w_a, w_q;
    logic [CW-1:0]    w_n, w_half;
    logic             w_in_range;
    logic [SQ_W-1:0]  w_m2, w_var;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_n      = r_cnt[r_p];
    assign w_half   = w_n >> 1;
    assign w_in_range = (32'(i_peer) < NP);
    assign w_m2     = SQ_W'(48'(r_mean) * 48'(r_mean));
    assign w_var    = (r_msq > w_m2) ? r_msq - w_m2 : '0;

    assign w_we    = (r_state == S_ADD) && (32'(r_cnt[r_apeer]) < MAX_REPS);
    assign w_waddr = AW'(32'(r_apeer) * MAX_REPS + 32'(r_cnt[r_apeer]));
    assign w_raddr = (r_state == S_MSCAN && r_idx == '0 && !r_rd_c)
                     ? AW'(32'(r_p) * MAX_REPS + 32'(r_cand))
                     : AW'(32'(r_p) * MAX_REPS + 32'(r_idx));

    lss_ram #(.WIDTH(LAT_W), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_alat),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lss_divsqrt #(.DW(CW)) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sqrt  (w_sqrt),
        .i_a     (w_a),
        .i_d     (w_n),
        .o_done  (w_done),
        .o_q     (w_q)
    );

    always_comb begin
        w_start = 1'b0;
        w_sqrt  = 1'b0;
        w_a     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_FINISH) begin
                        n_state = S_DIVW;
                    end else if (w_in_range) begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD:  n_state = S_IDLE;
            S_DIVW: begin
                if (!r_ovalid || !i_stall) begin
                    if (w_n == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        w_start = 1'b1;
                        w_a = SQ_W'(r_sum[r_p]);
                        n_state = S_DIV1;
                    end
                end
            end
            S_DIV1: begin
                if (w_done) begin
                    w_start = 1'b1;
                    w_a = r_sq[r_p];
                    n_state = S_DIV2;
                end
            end
            S_DIV2: if (w_done) n_state = S_SQ;
            S_SQ: begin
                w_start = 1'b1;
                w_sqrt  = 1'b1;
                w_a     = w_var;
                n_state = S_SQRT;
            end
            S_SQRT:  if (w_done) n_state = S_MSCAN;
            S_MSCAN: if (r_rd_v && r_idx == w_n) n_state = S_MWAIT;
            S_MWAIT: begin
                if (r_less <= CW'(w_half) && CW'(w_half) < r_leq) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MSCAN;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = (32'(r_p) == NP - 1) ? S_IDLE : S_DIVW;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_p      <= '0;
            r_rd_v   <= 1'b0;
            r_rd_c   <= 1'b0;
            for (int k = 0; k < NP; k++) begin
                r_cnt[k] <= '0;
                r_sum[k] <= '0;
                r_sq[k]  <= '0;
                r_min[k] <= '1;
                r_max[k] <= '0;
                r_ovf[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_apeer <= PW'(i_peer);
                    r_alat  <= i_latency;
                    r_alat2 <= 48'(i_latency) * 48'(i_latency);
                    r_p     <= '0;
                end
                S_ADD: begin
                    if (32'(r_cnt[r_apeer]) < MAX_REPS) begin
                        r_cnt[r_apeer] <= r_cnt[r_apeer] + CW'(1);
                        r_sum[r_apeer] <= r_sum[r_apeer] + SUM_W'(r_alat);
                        r_sq[r_apeer]  <= r_sq[r_apeer] + SQ_W'(r_alat2);
                        if (r_alat < r_min[r_apeer]) r_min[r_apeer] <= r_alat;
                        if (r_alat > r_max[r_apeer]) r_max[r_apeer] <= r_alat;
                    end else begin
                        r_ovf[r_apeer] <= 1'b1;
                    end
                end
                S_DIVW: begin
                    r_cand <= '0;
                    r_idx  <= '0;
                    r_rd_c <= 1'b0;
                    r_rd_v <= 1'b0;
                    r_less <= '0;
                    r_leq  <= '0;
                end
                S_DIV1: if (w_done) r_mean <= w_q[LAT_W-1:0];
                S_DIV2: if (w_done) r_msq <= w_q;
                S_SQRT: if (w_done) r_sd <= w_q[LAT_W-1:0];
                S_MSCAN: begin
                    // first issues the candidate read, then reads samples 0..n-1
                    if (!r_rd_c) begin
                        r_rd_c <= 1'b1;
                    end else begin
                        if (!r_rd_v) begin
                            r_cval <= w_rdata;
                            r_rd_v <= 1'b1;
                        end else begin
                            if (w_rdata < r_cval)  r_less <= r_less + CW'(1);
                            if (w_rdata <= r_cval) r_leq  <= r_leq + CW'(1);
                        end
                        if (r_idx != w_n) r_idx <= r_idx + CW'(1);
                    end
                end
                S_MWAIT: begin
                    r_med  <= r_cval;
                    r_cand <= r_cand + RW'(1);
                    r_idx  <= '0;
                    r_rd_c <= 1'b0;
                    r_rd_v <= 1'b0;
                    r_less <= '0;
                    r_leq  <= '0;
                end
                S_EMIT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out.peer    <= PEER_W'(r_p);
                        r_out.total   <= TOTAL_W'(w_n);
                        r_out.mean    <= (w_n == '0) ? '0 : r_mean;
                        r_out.sd      <= (w_n == '0) ? '0 : r_sd;
                        r_out.mn      <= (w_n == '0) ? '0 : r_min[r_p];
                        r_out.mx      <= (w_n == '0) ? '0 : r_max[r_p];
                        r_out.med     <= (w_n == '0) ? '0 : r_med;
                        r_out.dropped <= r_ovf[r_p];
                        r_out.last    <= (32'(r_p) == NP - 1);
                        r_cnt[r_p] <= '0;
                        r_sum[r_p] <= '0;
                        r_sq[r_p]  <= '0;
                        r_min[r_p] <= '1;
                        r_max[r_p] <= '0;
                        r_ovf[r_p] <= 1'b0;
                        r_p <= r_p + PW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_peer_out     = r_out.peer;
    assign o_sample_total = r_out.total;
    assign o_mean         = r_out.mean;
    assign o_std_dev      = r_out.sd;
    assign o_minimum      = r_out.mn;
    assign o_maximum      = r_out.mx;
    assign o_median       = r_out.med;
    assign o_dropped      = r_out.dropped;
    assign o_last         = r_out.last;
endmodule

[hdl/lss_ram.sv]
// ----------------------------------------------------------------------------
// lss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/lss_divsqrt.sv]
// ----------------------------------------------------------------------------
// lss_divsqrt
// Shared iterative unit: restoring divide (one quotient bit per cycle) or
// digit-by-digit integer square root (one result bit per cycle).
// ----------------------------------------------------------------------------
module lss_divsqrt
    import lss_pkg::*;
#(
    parameter int DW = TOTAL_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_sqrt,
    input  logic [SQ_W-1:0] i_a,
    input  logic [DW-1:0]   i_d,
    output logic            o_done,
    output logic [SQ_W-1:0] o_q
);
    logic [SQ_W-1:0]   r_a, n_a;
    logic [SQ_W-1:0]   r_q, n_q;
    logic [SQ_W+1:0]   r_rem, n_rem;
    logic [6:0]        r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_sqrt, n_sqrt;
    logic              r_done, n_done;
    logic [DW-1:0]     r_d, n_d;
    logic [SQ_W+1:0]   w_trial, w_sh;

    always_comb begin
        n_a = r_a; n_q = r_q; n_rem = r_rem; n_cnt = r_cnt;
        n_busy = r_busy; n_sqrt = r_sqrt; n_done = 1'b0; n_d = r_d;
        w_sh = '0; w_trial = '0;
        if (i_start) begin
            n_a = i_a; n_d = i_d; n_sqrt = i_sqrt; n_q = '0; n_rem = '0;
            n_busy = 1'b1;
            n_cnt = i_sqrt ? 7'(SQ_W / 2) : 7'(SQ_W);
        end else if (r_busy) begin
            if (r_sqrt) begin
                w_sh = {r_rem[SQ_W-1:0], r_a[SQ_W-1 -: 2]};
                w_trial = {r_q[SQ_W-1:0], 2'b01};
                n_a = {r_a[SQ_W-3:0], 2'b00};
                if (w_sh >= w_trial) begin
                    n_rem = w_sh - w_trial;
                    n_q = {r_q[SQ_W-2:0], 1'b1};
                end else begin
                    n_rem = w_sh;
                    n_q = {r_q[SQ_W-2:0], 1'b0};
                end
            end else begin
                w_sh = {r_rem[SQ_W:0], r_a[SQ_W-1]};
                w_trial = (SQ_W+2)'(r_d);
                n_a = {r_a[SQ_W-2:0], 1'b0};
                if (w_sh >= w_trial) begin
                    n_rem = w_sh - w_trial;
                    n_q = {r_q[SQ_W-2:0], 1'b1};
                end else begin
                    n_rem = w_sh;
                    n_q = {r_q[SQ_W-2:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a; r_q <= n_q; r_rem <= n_rem; r_sqrt <= n_sqrt; r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
